// ===== hdl/shc_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 hash core.
// No dependencies; every other file in hdl/ refers to this package by scope.
package shc_pkg;

    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 64;
    localparam int DIGEST_WORDS = 8;
    localparam int MAX_BYTES    = 4;
    localparam int LEN_HI_POS   = 14;   // word slot of the length high half
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = QUEUE_PTR_W + 1;

    localparam logic [31:0] PAD_MARK = 32'h8000_0000;

    localparam logic [31:0] IV_HASH [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // One packed 32-bit message word and its last flag, headed for the compression engine
    typedef struct packed {
        logic [31:0] word;
        logic        last;   // final length word of a message
    } t_word_item;

    typedef enum logic [2:0] {
        FR_TAKE,
        FR_MARK,
        FR_ZERO,
        FR_LEN_HI,
        FR_LEN_LO
    } t_front_state;

    typedef enum logic [1:0] {
        BK_LOAD,
        BK_ROUND,
        BK_UPDATE,
        BK_EMIT
    } t_back_state;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ===== hdl/shc_front.sv =====
// Front end: packs message bytes into 32-bit words and generates padding.
// Depends on shc_pkg; feeds shc_queue.
module shc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_message_word,
    input  logic [2:0]          i_valid_bytes,
    input  logic                i_end_of_message,
    input  logic                i_q_full,
    output logic                o_busy,
    output logic                o_push,
    output shc_pkg::t_word_item o_item
);

    shc_pkg::t_front_state r_state, n_state;
    logic [31:0] r_part;
    logic [1:0]  r_part_cnt;
    logic [3:0]  r_word_cnt;
    logic [63:0] r_bit_len;

    logic        accept;
    logic [2:0]  cnt;
    logic [31:0] in_masked;
    logic [31:0] part_masked;
    logic [63:0] merged;
    logic [2:0]  total;
    logic [3:0]  word_cnt_inc;
    logic        reach_len;

    assign o_busy = (r_state != shc_pkg::FR_TAKE) || i_q_full;
    assign accept = i_start && !o_busy;

    // counts above four are taken as four
    assign cnt = (i_valid_bytes > 3'(shc_pkg::MAX_BYTES)) ? 3'(shc_pkg::MAX_BYTES)
                                                          : i_valid_bytes;
    assign in_masked   = i_message_word & ~(32'hffff_ffff >> {cnt, 3'b000});
    assign part_masked = r_part & ~(32'hffff_ffff >> {r_part_cnt, 3'b000});
    assign merged      = {part_masked, 32'd0} | ({in_masked, 32'd0} >> {r_part_cnt, 3'b000});
    assign total       = {1'b0, r_part_cnt} + cnt;

    assign word_cnt_inc = r_word_cnt + 4'd1;
    assign reach_len    = (word_cnt_inc == 4'(shc_pkg::LEN_HI_POS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            shc_pkg::FR_TAKE: begin
                if (accept && i_end_of_message) n_state = shc_pkg::FR_MARK;
            end
            shc_pkg::FR_MARK, shc_pkg::FR_ZERO: begin
                if (!i_q_full) n_state = reach_len ? shc_pkg::FR_LEN_HI : shc_pkg::FR_ZERO;
            end
            shc_pkg::FR_LEN_HI: begin
                if (!i_q_full) n_state = shc_pkg::FR_LEN_LO;
            end
            shc_pkg::FR_LEN_LO: begin
                if (!i_q_full) n_state = shc_pkg::FR_TAKE;
            end
            default: n_state = shc_pkg::FR_TAKE;
        endcase
    end

    // outputs
    always_comb begin
        o_push      = 1'b0;
        o_item.word = 32'd0;
        o_item.last = 1'b0;
        case (r_state)
            shc_pkg::FR_TAKE: begin
                o_push      = accept && total[2];
                o_item.word = merged[63:32];
            end
            shc_pkg::FR_MARK: begin
                o_push      = !i_q_full;
                o_item.word = part_masked | (shc_pkg::PAD_MARK >> {r_part_cnt, 3'b000});
            end
            shc_pkg::FR_ZERO: begin
                o_push = !i_q_full;
            end
            shc_pkg::FR_LEN_HI: begin
                o_push      = !i_q_full;
                o_item.word = r_bit_len[63:32];
            end
            shc_pkg::FR_LEN_LO: begin
                o_push      = !i_q_full;
                o_item.word = r_bit_len[31:0];
                o_item.last = 1'b1;
            end
            default: o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= shc_pkg::FR_TAKE;
            r_part_cnt <= 2'd0;
            r_word_cnt <= 4'd0;
            r_bit_len  <= 64'd0;
        end else begin
            r_state <= n_state;
            if (o_push) r_word_cnt <= word_cnt_inc;
            if (accept) begin
                r_part_cnt <= total[1:0];
                r_bit_len  <= r_bit_len + {58'd0, cnt, 3'b000};
            end
            if (r_state == shc_pkg::FR_MARK && o_push) r_part_cnt <= 2'd0;
            if (r_state == shc_pkg::FR_LEN_LO && o_push) r_bit_len <= 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_part <= total[2] ? merged[31:0] : merged[63:32];
    end

endmodule

// ===== hdl/shc_queue.sv =====
// Short word queue between the packer and the compression engine.
// Depends on shc_pkg for depth and the entry type.
module shc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  shc_pkg::t_word_item i_item,
    input  logic                i_pop,
    output shc_pkg::t_word_item o_item,
    output logic                o_full,
    output logic                o_empty
);

    shc_pkg::t_word_item r_mem [shc_pkg::QUEUE_DEPTH];
    logic [shc_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [shc_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [shc_pkg::QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == shc_pkg::QUEUE_CNT_W'(shc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

// ===== hdl/shc_back.sv =====
// Back end: 16-word block load, 64-round compression, digest readout.
// Depends on shc_pkg; pulls words from shc_queue.
module shc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  shc_pkg::t_word_item i_item,
    output logic                o_pop,
    output logic                o_digest_valid,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_digest_index,
    output logic                o_digest_last
);

    shc_pkg::t_back_state r_state, n_state;
    logic [31:0] r_w [shc_pkg::BLOCK_WORDS];     // schedule window, r_w[0] is W[t]
    logic [31:0] r_v [shc_pkg::DIGEST_WORDS];    // a..h
    logic [31:0] r_h [shc_pkg::DIGEST_WORDS];    // chaining value
    logic [3:0]  r_load_cnt;
    logic [5:0]  r_round;
    logic [2:0]  r_emit_idx;
    logic        r_last;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_idx;
    logic        r_out_last;

    logic        load_done;
    logic [31:0] t1, t2, w_new, ch, maj;

    assign load_done = o_pop && (r_load_cnt == 4'(shc_pkg::BLOCK_WORDS - 1));

    assign ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1    = r_v[7] + shc_pkg::big_sigma1(r_v[4]) + ch
                 + shc_pkg::ROUND_K[r_round] + r_w[0];
    assign t2    = shc_pkg::big_sigma0(r_v[0]) + maj;
    assign w_new = shc_pkg::small_sigma1(r_w[14]) + r_w[9]
                 + shc_pkg::small_sigma0(r_w[1]) + r_w[0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            shc_pkg::BK_LOAD:   if (load_done) n_state = shc_pkg::BK_ROUND;
            shc_pkg::BK_ROUND:  if (r_round == 6'(shc_pkg::ROUNDS - 1)) n_state = shc_pkg::BK_UPDATE;
            shc_pkg::BK_UPDATE: n_state = r_last ? shc_pkg::BK_EMIT : shc_pkg::BK_LOAD;
            shc_pkg::BK_EMIT:   if (r_emit_idx == 3'(shc_pkg::DIGEST_WORDS - 1))
                                    n_state = shc_pkg::BK_LOAD;
            default:            n_state = shc_pkg::BK_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_pop = 1'b0;
        case (r_state)
            shc_pkg::BK_LOAD: o_pop = !i_q_empty;
            default:          o_pop = 1'b0;
        endcase
    end

    assign o_digest_valid = r_out_valid;
    assign o_digest_word  = r_out_word;
    assign o_digest_index = r_out_idx;
    assign o_digest_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= shc_pkg::BK_LOAD;
            r_load_cnt  <= 4'd0;
            r_round     <= 6'd0;
            r_emit_idx  <= 3'd0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < shc_pkg::DIGEST_WORDS; i++) r_h[i] <= shc_pkg::IV_HASH[i];
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == shc_pkg::BK_EMIT);
            if (o_pop) begin
                r_load_cnt <= r_load_cnt + 4'd1;
                r_last     <= i_item.last;
            end
            if (r_state == shc_pkg::BK_ROUND) r_round <= r_round + 6'd1;
            if (r_state == shc_pkg::BK_UPDATE) begin
                for (int i = 0; i < shc_pkg::DIGEST_WORDS; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (r_state == shc_pkg::BK_EMIT) begin
                r_emit_idx <= r_emit_idx + 3'd1;
                if (r_emit_idx == 3'(shc_pkg::DIGEST_WORDS - 1)) begin
                    for (int i = 0; i < shc_pkg::DIGEST_WORDS; i++)
                        r_h[i] <= shc_pkg::IV_HASH[i];
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (o_pop || r_state == shc_pkg::BK_ROUND) begin
            for (int i = 0; i < shc_pkg::BLOCK_WORDS - 1; i++) r_w[i] <= r_w[i + 1];
            r_w[shc_pkg::BLOCK_WORDS - 1] <= o_pop ? i_item.word : w_new;
        end
        if (load_done) begin
            for (int i = 0; i < shc_pkg::DIGEST_WORDS; i++) r_v[i] <= r_h[i];
        end else if (r_state == shc_pkg::BK_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (r_state == shc_pkg::BK_EMIT) begin
            r_out_word <= r_h[r_emit_idx];
            r_out_idx  <= r_emit_idx;
            r_out_last <= (r_emit_idx == 3'(shc_pkg::DIGEST_WORDS - 1));
        end
    end

endmodule

// ===== hdl/sha256_hash_core.sv =====
// SHA-256 hash core, top level: packer front end, word queue, compression back end.
// Depends on shc_pkg, shc_front, shc_queue and shc_back.
//
// Usage: drive i_message_word (first byte in bits 31:24), i_valid_bytes (0..4, larger
// counts act as 4) and i_end_of_message, and raise i_start; the item is taken at a
// clock edge where i_start is high and o_busy is low. A zero count is only meaningful
// on the final item; a final item with zero count as the first item hashes the empty
// message. After the final item the core pads the message itself and later presents
// the digest as eight consecutive single-cycle strobes on o_digest_valid, h0 first,
// with o_digest_last on h7. There is no output back-pressure: the receiver must take
// each word in the cycle it appears. In the back end a 64-byte block is loaded word by
// word from the queue, put through 64 rounds of compression and added into the chaining
// value; the single-round compression loop sets the sustained throughput. The front end
// packs one item per cycle, while o_busy is low, into a 4-entry queue, so short bursts
// go in at full speed; o_busy rises when the queue fills or padding is generated.
// After a final item the front end generates the padding, the back end runs one or two
// compressions, and the eight digest words are read out. The next message may be
// started while the digest is still being computed.
module sha256_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_end_of_message,
    output logic        o_busy,
    output logic        o_digest_valid,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_digest_last
);

    shc_pkg::t_word_item push_item;
    shc_pkg::t_word_item head_item;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // byte packing and padding
    shc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_message_word   (i_message_word),
        .i_valid_bytes    (i_valid_bytes),
        .i_end_of_message (i_end_of_message),
        .i_q_full         (q_full),
        .o_busy           (o_busy),
        .o_push           (push),
        .o_item           (push_item)
    );

    // decouples packing from compression
    shc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // compression and digest readout
    shc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_item         (head_item),
        .o_pop          (pop),
        .o_digest_valid (o_digest_valid),
        .o_digest_word  (o_digest_word),
        .o_digest_index (o_digest_index),
        .o_digest_last  (o_digest_last)
    );

endmodule
